// ===== design/pccc_pkg.sv =====
// Shared types, constants and the neighbour-cell table of the periodic close-contact check.
// Used by the channel interfaces and by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pccc_pkg;

  // fixed field widths of the words on the ports
  localparam int unsigned IN_IDX_W   = 6;
  localparam int unsigned IN_COORD_W = 20;
  localparam int unsigned AN_W       = 8;
  localparam int unsigned CODE_W     = 4;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned LIMIT_W    = 20;
  localparam int unsigned LIMIT_SQ_W = 2 * LIMIT_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // fixed point and squared-distance arithmetic
  localparam int unsigned FRAC_BITS = 10;
  localparam int unsigned DIST_W    = 46;
  localparam int unsigned HALF_W    = DIST_W / 2;
  localparam int unsigned SQ_W      = DIST_W + 1;
  localparam int unsigned SUM_W     = DIST_W + 2;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [SUM_W-1:0]  ONE_SQ   = SUM_W'(1) << (2 * FRAC_BITS);

  // scan sequencing
  localparam int unsigned NUM_CODES  = 13;
  localparam int unsigned RESULT_MAX = 64;
  localparam int unsigned VEC_READS  = 6;
  localparam int unsigned VSEL_W     = 3;

  // defaults of the top-level parameters
  localparam int unsigned DEF_MAX_ATOMS   = 64;
  localparam int unsigned DEF_COORD_WIDTH = 20;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_SCAN = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONTACT_LIMIT = 3'd0,
    REG_ATOM_COUNT    = 3'd1,
    REG_VEC_A_START   = 3'd2,
    REG_VEC_A_STOP    = 3'd3,
    REG_VEC_B_START   = 3'd4,
    REG_VEC_B_STOP    = 3'd5,
    REG_VEC_C_START   = 3'd6,
    REG_VEC_C_STOP    = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VEC,
    ST_ROW,
    ST_PAIR,
    ST_BAD,
    ST_DRAIN
  } st_e;

  typedef enum logic [1:0] {
    TOK_VEC,
    TOK_ROW,
    TOK_PAIR,
    TOK_BAD
  } tok_kind_e;

  // register state the sequencer needs
  typedef struct packed {
    logic [COUNT_W-1:0]                   count;
    logic [VEC_READS-1:0][IN_IDX_W-1:0]   vec_idx;
  } scan_cfg_t;

  // command from the sequencer to the datapath, one per cycle
  typedef struct packed {
    logic                  wr_en;
    logic [IN_IDX_W-1:0]   wr_idx;
    logic                  trans_clr;
    logic                  issue;
    tok_kind_e             kind;
    logic [IN_IDX_W-1:0]   rd_idx;
    logic signed [1:0]     coef;
    logic                  last;
    logic [IN_IDX_W-1:0]   row_idx;
  } dp_cmd_t;

  // status from the datapath back to the sequencer
  typedef struct packed {
    logic advance;
    logic busy;
  } dp_status_t;

  // lattice coefficients {a, b, c} per cell code, two bits each in two's complement
  localparam logic [5:0] COEF_TAB [16] = '{
    6'b01_00_00, 6'b01_01_00, 6'b00_01_00, 6'b11_01_00,
    6'b00_00_01, 6'b01_01_01, 6'b00_01_01, 6'b11_01_01,
    6'b01_00_01, 6'b11_00_01, 6'b01_11_01, 6'b00_11_01,
    6'b11_11_01, 6'b00_00_00, 6'b00_00_00, 6'b00_00_00
  };

  // coefficient of lattice vector k (0 = a, 1 = b, 2 = c) for a cell code
  function automatic logic signed [1:0] cell_coef(input logic [CODE_W-1:0] code,
                                                  input logic [1:0] k);
    logic [5:0] entry;
    entry = COEF_TAB[code];
    case (k)
      2'd0:    cell_coef = entry[5:4];
      2'd1:    cell_coef = entry[3:2];
      default: cell_coef = entry[1:0];
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== design/pccc_if.sv =====
// Valid/ready channel interfaces for input words and result words.
// Depends on pccc_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pccc_in_if import pccc_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [IN_IDX_W-1:0]          atom_index;
  logic signed [IN_COORD_W-1:0] pos_x;
  logic signed [IN_COORD_W-1:0] pos_y;
  logic signed [IN_COORD_W-1:0] pos_z;
  logic signed [AN_W-1:0]       atomic_number;
  logic [CODE_W-1:0]            cell_code;

  modport source (output valid, func, atom_index, pos_x, pos_y, pos_z, atomic_number,
                  cell_code, input ready);
  modport sink (input valid, func, atom_index, pos_x, pos_y, pos_z, atomic_number,
                cell_code, output ready);
endinterface

interface pccc_out_if import pccc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [IN_IDX_W-1:0] row_atom;
  logic [IN_IDX_W-1:0] other_atom;
  logic [DIST_W-1:0]   dist_sq;
  logic                in_contact;
  logic                suspicious;
  logic                bad_request;
  logic                last_of_run;

  modport source (output valid, row_atom, other_atom, dist_sq, in_contact, suspicious,
                  bad_request, last_of_run, input ready);
  modport sink (input valid, row_atom, other_atom, dist_sq, in_contact, suspicious,
                bad_request, last_of_run, output ready);
endinterface

`default_nettype wire

// ===== design/periodic_close_contact_check.sv =====
// Top level of the periodic close-contact check: channels, configuration port and
// the register file, sequencer and datapath. Depends on pccc_pkg and pccc_if.
`timescale 1ns / 1ps
`default_nettype none

// Atoms are loaded one word at a time into a store with one write and one registered
// read port (no result). A scan word names a row atom and a neighbour cell; the block
// reads the six lattice end points and the row atom, then reads one stored atom per
// cycle while the result side does not stall, and emits one result word per atom
// through a four-stage pipeline (read, difference, square, sum). A scan holds off the
// next input word until all its reads are issued and the pipeline has drained; a bad
// row index yields one flagged word, and a load does not leave the idle state. The next
// input word is taken as soon as the pipeline is empty, while the final result may
// still wait in the output register. Configuration is to be written through cfg_we_i,
// cfg_idx_i and cfg_data_i only while no scan is in flight; the block does not enforce this.
module periodic_close_contact_check import pccc_pkg::*; #(
  parameter int unsigned MAX_ATOMS   = DEF_MAX_ATOMS,
  parameter int unsigned COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pccc_in_if.sink               in_i,
  pccc_out_if.source            out_o
);

  scan_cfg_t             scan_cfg;
  logic [LIMIT_SQ_W-1:0] limit_sq;
  dp_cmd_t               cmd;
  dp_status_t            status;
  logic                  in_ready;

  // configuration registers
  pccc_cfg #(
    .MAX_ATOMS (MAX_ATOMS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .scan_cfg_o (scan_cfg),
    .limit_sq_o (limit_sq)
  );

  // sequencer
  pccc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_i.valid),
    .in_func_i       (in_i.func),
    .in_atom_index_i (in_i.atom_index),
    .in_cell_code_i  (in_i.cell_code),
    .scan_cfg_i      (scan_cfg),
    .status_i        (status),
    .in_ready_o      (in_ready),
    .cmd_o           (cmd)
  );

  assign in_i.ready = in_ready;

  // store and arithmetic pipeline
  pccc_dp #(
    .MAX_ATOMS   (MAX_ATOMS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .pos_x_i         (in_i.pos_x),
    .pos_y_i         (in_i.pos_y),
    .pos_z_i         (in_i.pos_z),
    .atomic_number_i (in_i.atomic_number),
    .limit_sq_i      (limit_sq),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .row_atom_o      (out_o.row_atom),
    .other_atom_o    (out_o.other_atom),
    .dist_sq_o       (out_o.dist_sq),
    .in_contact_o    (out_o.in_contact),
    .suspicious_o    (out_o.suspicious),
    .bad_request_o   (out_o.bad_request),
    .last_of_run_o   (out_o.last_of_run),
    .status_o        (status)
  );

endmodule

`default_nettype wire

// ===== design/pccc_cfg.sv =====
// Configuration register file: contact limit (kept squared), atom count and lattice indexes.
// Depends on pccc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pccc_cfg import pccc_pkg::*; #(
  parameter int unsigned MAX_ATOMS = DEF_MAX_ATOMS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output scan_cfg_t             scan_cfg_o,
  output logic [LIMIT_SQ_W-1:0] limit_sq_o
);

  localparam int unsigned CNT_MAX = (MAX_ATOMS < RESULT_MAX) ? MAX_ATOMS : RESULT_MAX;
  localparam logic [COUNT_W-1:0] CNT_SAT = COUNT_W'(CNT_MAX);

  logic [LIMIT_W-1:0]                 limit_q;
  logic [LIMIT_SQ_W-1:0]              limit_sq_q;
  logic [COUNT_W-1:0]                 count_q;
  logic [VEC_READS-1:0][IN_IDX_W-1:0] vec_q;
  logic [COUNT_W-1:0]                 count_wr;

  // count saturates to what the store and the result space allow
  assign count_wr = (cfg_data_i[COUNT_W-1:0] > CNT_SAT) ? CNT_SAT : cfg_data_i[COUNT_W-1:0];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
      count_q <= COUNT_W'(1);
      vec_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_CONTACT_LIMIT: limit_q  <= cfg_data_i[LIMIT_W-1:0];
        REG_ATOM_COUNT:    count_q  <= count_wr;
        REG_VEC_A_START:   vec_q[0] <= cfg_data_i[IN_IDX_W-1:0];
        REG_VEC_A_STOP:    vec_q[1] <= cfg_data_i[IN_IDX_W-1:0];
        REG_VEC_B_START:   vec_q[2] <= cfg_data_i[IN_IDX_W-1:0];
        REG_VEC_B_STOP:    vec_q[3] <= cfg_data_i[IN_IDX_W-1:0];
        REG_VEC_C_START:   vec_q[4] <= cfg_data_i[IN_IDX_W-1:0];
        REG_VEC_C_STOP:    vec_q[5] <= cfg_data_i[IN_IDX_W-1:0];
      endcase
    end
  end

  // squared limit, registered from the limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_sq_q <= '0;
    end else begin
      limit_sq_q <= limit_q * limit_q;
    end
  end

  assign scan_cfg_o.count   = count_q;
  assign scan_cfg_o.vec_idx = vec_q;
  assign limit_sq_o         = limit_sq_q;

endmodule

`default_nettype wire

// ===== design/pccc_ctrl.sv =====
// Scan sequencer: accepts input words and issues store reads for lattice vectors,
// the row atom and each pair. Depends on pccc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pccc_ctrl import pccc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_func_i,
  input  logic [IN_IDX_W-1:0] in_atom_index_i,
  input  logic [CODE_W-1:0]   in_cell_code_i,
  input  scan_cfg_t           scan_cfg_i,
  input  dp_status_t          status_i,
  output logic                in_ready_o,
  output dp_cmd_t             cmd_o
);

  st_e                 state_q, state_d;
  logic [VSEL_W-1:0]   vsel_q;
  logic [IN_IDX_W-1:0] j_q;
  logic [IN_IDX_W-1:0] row_q;
  logic [CODE_W-1:0]   code_q;

  logic              accept;
  logic              is_scan;
  logic              code_ok;
  logic              bad_row;
  logic              pair_last;
  logic              vec_last;
  logic signed [1:0] vcoef;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_scan    = (func_e'(in_func_i) == FUNC_SCAN);
  assign code_ok    = (in_cell_code_i < CODE_W'(NUM_CODES));
  assign bad_row    = ({1'b0, in_atom_index_i} >= scan_cfg_i.count);
  assign pair_last  = (({1'b0, j_q} + COUNT_W'(1)) == scan_cfg_i.count);
  assign vec_last   = (vsel_q == VSEL_W'(VEC_READS - 1));

  // start index enters negated, stop index as is
  assign vcoef = vsel_q[0] ? cell_coef(code_q, vsel_q[2:1]) : -cell_coef(code_q, vsel_q[2:1]);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_scan && code_ok) begin
          state_d = bad_row ? ST_BAD : ST_VEC;
        end
      end
      ST_VEC: begin
        if (status_i.advance && vec_last) begin
          state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        if (status_i.advance) begin
          state_d = ST_PAIR;
        end
      end
      ST_PAIR: begin
        if (status_i.advance && pair_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_BAD: begin
        if (status_i.advance) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd_o           = '0;
    cmd_o.kind      = TOK_PAIR;
    cmd_o.wr_idx    = in_atom_index_i;
    cmd_o.row_idx   = row_q;
    cmd_o.rd_idx    = row_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.wr_en     = accept && !is_scan;
        cmd_o.trans_clr = accept && is_scan && code_ok && !bad_row;
      end
      ST_VEC: begin
        cmd_o.issue  = status_i.advance;
        cmd_o.kind   = TOK_VEC;
        cmd_o.rd_idx = scan_cfg_i.vec_idx[vsel_q];
        cmd_o.coef   = vcoef;
      end
      ST_ROW: begin
        cmd_o.issue = status_i.advance;
        cmd_o.kind  = TOK_ROW;
      end
      ST_PAIR: begin
        cmd_o.issue  = status_i.advance;
        cmd_o.kind   = TOK_PAIR;
        cmd_o.rd_idx = j_q;
        cmd_o.last   = pair_last;
      end
      ST_BAD: begin
        cmd_o.issue = status_i.advance;
        cmd_o.kind  = TOK_BAD;
        cmd_o.last  = 1'b1;
      end
      ST_DRAIN: begin
        cmd_o.issue = 1'b0;
      end
      default: cmd_o.issue = 1'b0;
    endcase
  end

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vsel_q  <= '0;
      j_q     <= '0;
      row_q   <= '0;
      code_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept && is_scan) begin
        row_q  <= in_atom_index_i;
        code_q <= in_cell_code_i;
        vsel_q <= '0;
        j_q    <= '0;
      end
      if (state_q == ST_VEC && status_i.advance) begin
        vsel_q <= vsel_q + VSEL_W'(1);
      end
      if (state_q == ST_PAIR && status_i.advance) begin
        j_q <= j_q + IN_IDX_W'(1);
      end
    end
  end

`ifndef SYNTH
  a_ready_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !status_i.busy)
    else $error("input taken while the pipeline still holds a scan");
  a_issue_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> status_i.advance)
    else $error("read issued while the pipeline is stalled");
  a_clr_starts_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.trans_clr |=> state_q == ST_VEC)
    else $error("translation cleared without a lattice read phase");
`endif

endmodule

`default_nettype wire

// ===== design/pccc_dp.sv =====
// Datapath: atom store, translation accumulator, difference/square/sum pipeline and
// the output register. Depends on pccc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pccc_dp import pccc_pkg::*; #(
  parameter int unsigned MAX_ATOMS   = DEF_MAX_ATOMS,
  parameter int unsigned COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dp_cmd_t                      cmd_i,
  input  logic signed [IN_COORD_W-1:0] pos_x_i,
  input  logic signed [IN_COORD_W-1:0] pos_y_i,
  input  logic signed [IN_COORD_W-1:0] pos_z_i,
  input  logic signed [AN_W-1:0]       atomic_number_i,
  input  logic [LIMIT_SQ_W-1:0]        limit_sq_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [IN_IDX_W-1:0]          row_atom_o,
  output logic [IN_IDX_W-1:0]          other_atom_o,
  output logic [DIST_W-1:0]            dist_sq_o,
  output logic                         in_contact_o,
  output logic                         suspicious_o,
  output logic                         bad_request_o,
  output logic                         last_of_run_o,
  output dp_status_t                   status_o
);

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned AIW = $clog2(MAX_ATOMS);
  localparam int unsigned XW  = IN_IDX_W + AIW;
  localparam int unsigned MW  = 3 * CW + 1;
  localparam int unsigned TW  = CW + 3;
  localparam int unsigned DW  = CW + 4;
  localparam int unsigned AW  = (DW > HALF_W + 1) ? DW : HALF_W + 1;

  logic [MW-1:0] mem_q [MAX_ATOMS];
  logic [MW-1:0] rd_q;

  logic          advance;

  logic [XW-1:0] wr_ext, rd_ext;
  logic          wr_inrange, rd_inrange;
  logic [MW-1:0] wr_word;
  logic signed [IN_COORD_W-1:0]  pos_in [3];
  logic [CW+IN_COORD_W-1:0]      pos_wide [3];

  // stage 1: store read word
  logic                v1_q;
  tok_kind_e           kind1_q;
  logic signed [1:0]   coef1_q;
  logic                inr1_q;
  logic [IN_IDX_W-1:0] j1_q;
  logic                last1_q;

  // row atom and translation held for the scan
  logic signed [CW-1:0] row_c_q [3];
  logic                 row_real_q;
  logic signed [TW-1:0] trans_q [3];

  // stage 1 arithmetic
  logic signed [CW-1:0] rd_c [3];
  logic signed [DW-1:0] diff [3];
  logic [DW-1:0]        diff_abs [3];
  logic [AW-1:0]        abs_ext [3];

  // stage 2: magnitudes
  logic                v2_q, bad2_q, last2_q, real2_q;
  logic [IN_IDX_W-1:0] j2_q;
  logic [HALF_W-1:0]   mag2_q [3];
  logic                big2_q [3];

  // stage 3: squares
  logic                v3_q, bad3_q, last3_q, real3_q;
  logic [IN_IDX_W-1:0] j3_q;
  logic [SQ_W-1:0]     sq3_q [3];

  // output register
  logic                out_v_q;
  logic [IN_IDX_W-1:0] row_o_q, j_o_q;
  logic [DIST_W-1:0]   dist_o_q;
  logic                cont_o_q, susp_o_q, bad_o_q, last_o_q;

  logic [SUM_W-1:0]    sum;

  assign advance          = !out_v_q || out_ready_i;
  assign status_o.advance = advance;
  assign status_o.busy    = v1_q || v2_q || v3_q;

  // store addressing, writes beyond the store are dropped and lattice reads beyond it are ignored
  assign wr_ext     = XW'(cmd_i.wr_idx);
  assign rd_ext     = XW'(cmd_i.rd_idx);
  assign wr_inrange = (wr_ext < XW'(MAX_ATOMS));
  assign rd_inrange = (rd_ext < XW'(MAX_ATOMS));

  // load word: coordinates sign extended or cut to the stored width
  assign pos_in[0] = pos_x_i;
  assign pos_in[1] = pos_y_i;
  assign pos_in[2] = pos_z_i;
  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      pos_wide[ax] = {{CW{pos_in[ax][IN_COORD_W-1]}}, pos_in[ax]};
      wr_word[ax*CW +: CW] = pos_wide[ax][CW-1:0];
    end
    wr_word[MW-1] = !atomic_number_i[AN_W-1] && (atomic_number_i != '0);
  end

  // atom store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_inrange) begin
      mem_q[wr_ext[AIW-1:0]] <= wr_word;
    end
    if (cmd_i.issue && advance) begin
      rd_q <= mem_q[rd_ext[AIW-1:0]];
    end
  end

  // stage 1 tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (advance) begin
      v1_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind1_q <= cmd_i.kind;
      coef1_q <= cmd_i.coef;
      inr1_q  <= rd_inrange;
      j1_q    <= cmd_i.rd_idx;
      last1_q <= cmd_i.last;
    end
  end

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      rd_c[ax] = rd_q[ax*CW +: CW];
    end
  end

  // lattice translation: add or subtract each vector end point
  always_ff @(posedge clk_i) begin
    if (cmd_i.trans_clr) begin
      for (int ax = 0; ax < 3; ax++) begin
        trans_q[ax] <= '0;
      end
    end else if (advance && v1_q && kind1_q == TOK_VEC && inr1_q) begin
      for (int ax = 0; ax < 3; ax++) begin
        case (coef1_q)
          2'sb01:  trans_q[ax] <= trans_q[ax] + TW'(rd_c[ax]);
          2'sb11:  trans_q[ax] <= trans_q[ax] - TW'(rd_c[ax]);
          default: trans_q[ax] <= trans_q[ax];
        endcase
      end
    end
  end

  // row atom capture
  always_ff @(posedge clk_i) begin
    if (advance && v1_q && kind1_q == TOK_ROW) begin
      for (int ax = 0; ax < 3; ax++) begin
        row_c_q[ax] <= rd_c[ax];
      end
      row_real_q <= rd_q[MW-1];
    end
  end

  // difference to the translated atom and its magnitude
  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      diff[ax]     = DW'(row_c_q[ax]) - DW'(rd_c[ax]) - DW'(trans_q[ax]);
      diff_abs[ax] = diff[ax][DW-1] ? DW'(-diff[ax]) : DW'(diff[ax]);
      abs_ext[ax]  = AW'(diff_abs[ax]);
    end
  end

  // stage 2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (advance) begin
      v2_q <= v1_q && (kind1_q == TOK_PAIR || kind1_q == TOK_BAD);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      bad2_q  <= (kind1_q == TOK_BAD);
      last2_q <= last1_q;
      j2_q    <= j1_q;
      real2_q <= row_real_q && rd_q[MW-1];
      for (int ax = 0; ax < 3; ax++) begin
        mag2_q[ax] <= abs_ext[ax][HALF_W-1:0];
        big2_q[ax] <= ((abs_ext[ax] >> HALF_W) != '0);
      end
    end
  end

  // stage 3: one square per axis, oversized parts stand for a saturated value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (advance) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      bad3_q  <= bad2_q;
      last3_q <= last2_q;
      j3_q    <= j2_q;
      real3_q <= real2_q;
      for (int ax = 0; ax < 3; ax++) begin
        sq3_q[ax] <= big2_q[ax] ? (SQ_W'(1) << DIST_W) : SQ_W'(mag2_q[ax] * mag2_q[ax]);
      end
    end
  end

  // sum of squares, flags on the exact sum
  assign sum = SUM_W'(sq3_q[0]) + SUM_W'(sq3_q[1]) + SUM_W'(sq3_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && v3_q) begin
      row_o_q  <= cmd_i.row_idx;
      last_o_q <= last3_q;
      bad_o_q  <= bad3_q;
      if (bad3_q) begin
        j_o_q    <= '0;
        dist_o_q <= '0;
        cont_o_q <= 1'b0;
        susp_o_q <= 1'b0;
      end else begin
        j_o_q    <= j3_q;
        dist_o_q <= (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
        cont_o_q <= (sum <= SUM_W'(limit_sq_i));
        susp_o_q <= real3_q && (sum < ONE_SQ);
      end
    end
  end

  assign out_valid_o   = out_v_q;
  assign row_atom_o    = row_o_q;
  assign other_atom_o  = j_o_q;
  assign dist_sq_o     = dist_o_q;
  assign in_contact_o  = cont_o_q;
  assign suspicious_o  = susp_o_q;
  assign bad_request_o = bad_o_q;
  assign last_of_run_o = last_o_q;

`ifndef SYNTH
  a_bad_word_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && bad_o_q |-> !cont_o_q && !susp_o_q && last_o_q && dist_o_q == '0)
    else $error("bad request word carries distance data");
  a_susp_below_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && susp_o_q |-> SUM_W'(dist_o_q) < ONE_SQ)
    else $error("suspicious flag on a distance of one or more");
  a_sum_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && advance |=> out_v_q)
    else $error("pair word lost between the sum stage and the output");
`endif

endmodule

`default_nettype wire

// ===== dv/pccc_contact_monitor.sv =====
// Result monitor for the periodic close-contact check: predicts every result word from the
// accepted input words and register writes, and compares it with what the block emits.
// Depends on pccc_pkg and the channel interfaces in pccc_if.
`timescale 1ns / 1ps

module pccc_contact_monitor import pccc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pccc_in_if                    in_mon_i,
  pccc_out_if                   out_mon_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  localparam int unsigned REPORT_MAX = 10;
  localparam int unsigned SLOTS      = DEF_MAX_ATOMS;

  // lattice steps {a, b, c} of each neighbour cell
  localparam int LATTICE_STEP [NUM_CODES][3] = '{
    '{ 1,  0, 0}, '{ 1,  1, 0}, '{ 0,  1, 0}, '{-1,  1, 0}, '{ 0,  0, 1},
    '{ 1,  1, 1}, '{ 0,  1, 1}, '{-1,  1, 1}, '{ 1,  0, 1}, '{-1,  0, 1},
    '{ 1, -1, 1}, '{ 0, -1, 1}, '{-1, -1, 1}
  };

  typedef struct packed {
    logic [IN_IDX_W-1:0] row_atom;
    logic [IN_IDX_W-1:0] other_atom;
    logic [DIST_W-1:0]   dist_sq;
    logic                in_contact;
    logic                suspicious;
    logic                bad_request;
    logic                last_of_run;
  } contact_word_t;

  contact_word_t                expected_q [$];
  logic signed [IN_COORD_W-1:0] atom_pos [SLOTS][3];
  logic                         is_real [SLOTS];
  logic [LIMIT_W-1:0]           contact_limit;
  logic [COUNT_W-1:0]           atom_count;
  logic [IN_IDX_W-1:0]          vec_sel [VEC_READS];
  int unsigned                  mismatches;

  // expected words of one scan, pushed in emission order
  function automatic void predict_scan(input logic [IN_IDX_W-1:0] row,
                                       input logic [CODE_W-1:0] code);
    int unsigned   n;
    longint        shift [3];
    longint        d;
    longint        mag;
    longint        sum;
    longint        limit_sq;
    contact_word_t w;
    if (code >= NUM_CODES) return;
    n = (atom_count > RESULT_MAX) ? RESULT_MAX : atom_count;
    w = '0;
    w.row_atom = row;
    // row outside the scanned range: one flagged word only
    if (row >= n) begin
      w.bad_request = 1'b1;
      w.last_of_run = 1'b1;
      expected_q.push_back(w);
      return;
    end
    for (int ax = 0; ax < 3; ax++) begin
      shift[ax] = 0;
      for (int k = 0; k < 3; k++) begin
        shift[ax] += LATTICE_STEP[code][k] * (longint'(atom_pos[vec_sel[2*k+1]][ax])
                                            - longint'(atom_pos[vec_sel[2*k]][ax]));
      end
    end
    limit_sq = longint'(contact_limit) * longint'(contact_limit);
    for (int j = 0; j < n; j++) begin
      sum = 0;
      for (int ax = 0; ax < 3; ax++) begin
        d   = longint'(atom_pos[row][ax]) - longint'(atom_pos[j][ax]) - shift[ax];
        mag = (d < 0) ? -d : d;
        sum += (mag >= (longint'(1) << HALF_W)) ? (longint'(1) << DIST_W) : mag * mag;
      end
      w.other_atom  = IN_IDX_W'(j);
      w.dist_sq     = (sum > longint'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum);
      w.in_contact  = (sum <= limit_sq);
      w.suspicious  = (sum < (longint'(1) << (2 * FRAC_BITS))) && is_real[row] && is_real[j];
      w.bad_request = 1'b0;
      w.last_of_run = (j == n - 1);
      expected_q.push_back(w);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    contact_word_t got;
    contact_word_t want;
    if (!rst_ni) begin
      contact_limit = '0;
      atom_count    = COUNT_W'(1);
      foreach (vec_sel[i]) vec_sel[i] = '0;
      expected_q.delete();
      mismatches    = 0;
      fail_count_o  = 0;
      pending_o     = 0;
    end else begin
      // compare an emitted word with the oldest expectation
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.row_atom    = out_mon_i.row_atom;
        got.other_atom  = out_mon_i.other_atom;
        got.dist_sq     = out_mon_i.dist_sq;
        got.in_contact  = out_mon_i.in_contact;
        got.suspicious  = out_mon_i.suspicious;
        got.bad_request = out_mon_i.bad_request;
        got.last_of_run = out_mon_i.last_of_run;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: unexpected result word row %0d other %0d dist_sq %h", $time,
                     got.row_atom, got.other_atom, got.dist_sq);
        end else begin
          want = expected_q.pop_front();
          if (got.row_atom !== want.row_atom || got.other_atom !== want.other_atom ||
              got.dist_sq !== want.dist_sq || got.in_contact !== want.in_contact ||
              got.suspicious !== want.suspicious || got.bad_request !== want.bad_request ||
              got.last_of_run !== want.last_of_run) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("%0t: result word mismatch", $time);
              $display("  expected row %0d other %0d dist_sq %h contact %b susp %b bad %b last %b",
                       want.row_atom, want.other_atom, want.dist_sq, want.in_contact,
                       want.suspicious, want.bad_request, want.last_of_run);
              $display("  actual   row %0d other %0d dist_sq %h contact %b susp %b bad %b last %b",
                       got.row_atom, got.other_atom, got.dist_sq, got.in_contact,
                       got.suspicious, got.bad_request, got.last_of_run);
            end
          end
        end
      end

      // register writes
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_CONTACT_LIMIT: contact_limit = cfg_data_i[LIMIT_W-1:0];
          REG_ATOM_COUNT:    atom_count    = cfg_data_i[COUNT_W-1:0];
          default:           vec_sel[cfg_idx_i - REG_VEC_A_START] = cfg_data_i[IN_IDX_W-1:0];
        endcase
      end

      // accepted input word: store an atom or predict a scan
      if (in_mon_i.valid && in_mon_i.ready) begin
        if (in_mon_i.func == FUNC_LOAD) begin
          atom_pos[in_mon_i.atom_index][0] = in_mon_i.pos_x;
          atom_pos[in_mon_i.atom_index][1] = in_mon_i.pos_y;
          atom_pos[in_mon_i.atom_index][2] = in_mon_i.pos_z;
          is_real[in_mon_i.atom_index]     = (in_mon_i.atomic_number > 0);
        end else begin
          predict_scan(in_mon_i.atom_index, in_mon_i.cell_code);
        end
      end

      fail_count_o = mismatches;
      pending_o    = expected_q.size();
    end
  end

endmodule

// ===== dv/tb_periodic_close_contact_check.sv =====
// Testbench top of the periodic close-contact check: clock, reset, stimulus, result-side
// flow control and the verdict. Depends on pccc_pkg, pccc_if, the block and pccc_contact_monitor.
`timescale 1ns / 1ps

module tb_periodic_close_contact_check;
  import pccc_pkg::*;

  localparam int unsigned RUN_ITEMS     = 320;
  localparam int unsigned QUIET_ITEMS   = 40;
  localparam int unsigned DRAIN_CYCLES  = 100;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned TIME_LIMIT_NS = 6_000_000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           fail_count;
  int unsigned           pending;
  int unsigned           items_sent;
  int unsigned           cur_count;
  bit                    idle_on;
  bit                    hold_req;

  pccc_in_if  in_ch ();
  pccc_out_if out_ch ();

  periodic_close_contact_check dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  pccc_contact_monitor contact_mon (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #(TIME_LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stall bursts and one long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [IN_COORD_W-1:0] rand_coord();
    // each coordinate lies within 2.0 of the origin half the time so that contacts occur
    if ($urandom_range(0, 1) == 0) return IN_COORD_W'($urandom_range(0, 4095) - 2048);
    return IN_COORD_W'($urandom);
  endfunction

  // one input word, with a random gap before it when idling is on
  task automatic send_word(input func_e f, input logic [IN_IDX_W-1:0] idx,
                           input logic [IN_COORD_W-1:0] x, input logic [IN_COORD_W-1:0] y,
                           input logic [IN_COORD_W-1:0] z, input logic [AN_W-1:0] an,
                           input logic [CODE_W-1:0] code);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_ch.valid         <= 1'b1;
    in_ch.func          <= f;
    in_ch.atom_index    <= idx;
    in_ch.pos_x         <= x;
    in_ch.pos_y         <= y;
    in_ch.pos_z         <= z;
    in_ch.atomic_number <= an;
    in_ch.cell_code     <= code;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (f == FUNC_LOAD || code < NUM_CODES) items_sent++;
  endtask

  task automatic write_reg(input cfg_reg_e r, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= r;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    if (r == REG_ATOM_COUNT)
      cur_count = (value[COUNT_W-1:0] > RESULT_MAX) ? RESULT_MAX : value[COUNT_W-1:0];
  endtask

  // stop offering words and wait for every expected result, then let the block settle
  task automatic wait_idle(input int unsigned settle);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  initial begin
    int unsigned round;
    int unsigned n;
    int unsigned k;
    logic [IN_IDX_W-1:0] row;
    logic [IN_IDX_W-1:0] vstart;
    bit quiet;

    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = '0;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.func          = FUNC_LOAD;
    in_ch.atom_index    = '0;
    in_ch.pos_x         = '0;
    in_ch.pos_y         = '0;
    in_ch.pos_z         = '0;
    in_ch.atomic_number = '0;
    in_ch.cell_code     = '0;
    items_sent          = 0;
    cur_count           = 1;
    idle_on             = 1'b1;
    hold_req            = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // corner atoms: coordinate extremes, non-real marks, pairs under 1.0 apart
    send_word(FUNC_LOAD, 6'd0, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 8'd127, 4'd0);
    send_word(FUNC_LOAD, 6'd1, 20'h80000, 20'h80000, 20'h80000, 8'hFF, 4'hF);
    send_word(FUNC_LOAD, 6'd2, 20'd0, 20'd0, 20'd0, 8'd0, 4'd0);
    send_word(FUNC_LOAD, 6'd3, 20'd1024, 20'd0, 20'd0, 8'd1, 4'd0);
    send_word(FUNC_LOAD, 6'd4, 20'd512, -20'sd512, 20'd300, 8'd6, 4'd0);
    send_word(FUNC_LOAD, 6'd5, 20'd2047, 20'd0, 20'd0, 8'd8, 4'd0);

    // reset settings: one atom, zero translation, zero limit
    send_word(FUNC_SCAN, 6'd0, 20'($urandom), 20'($urandom), 20'($urandom), 8'($urandom), 4'd0);
    send_word(FUNC_SCAN, 6'd5, 20'($urandom), 20'($urandom), 20'($urandom), 8'($urandom), 4'd4);
    send_word(FUNC_SCAN, 6'd0, 20'($urandom), 20'($urandom), 20'($urandom), 8'($urandom), 4'd13);
    send_word(FUNC_SCAN, 6'd0, 20'($urandom), 20'($urandom), 20'($urandom), 8'($urandom), 4'd15);

    // widest limit, lattice vectors between the corner atoms, every cell code
    wait_idle(DRAIN_CYCLES);
    write_reg(REG_CONTACT_LIMIT, 20'hFFFFF);
    write_reg(REG_ATOM_COUNT, 20'd6);
    write_reg(REG_VEC_A_START, 20'd0);
    write_reg(REG_VEC_A_STOP, 20'd1);
    write_reg(REG_VEC_B_START, 20'd2);
    write_reg(REG_VEC_B_STOP, 20'd3);
    write_reg(REG_VEC_C_START, 20'd4);
    write_reg(REG_VEC_C_STOP, 20'd5);
    for (int c = 0; c < NUM_CODES; c++)
      send_word(FUNC_SCAN, IN_IDX_W'(c % 6), 20'($urandom), 20'($urandom), 20'($urandom),
                8'($urandom), CODE_W'(c));

    // fill the whole store so that any count and vector pick reads loaded atoms
    for (int s = 0; s < DEF_MAX_ATOMS; s++)
      send_word(FUNC_LOAD, IN_IDX_W'(s), rand_coord(), rand_coord(), rand_coord(),
                8'($urandom), 4'($urandom));

    // random rounds, each under its own register setting
    round = 0;
    while (items_sent < RUN_ITEMS) begin
      quiet = (items_sent + QUIET_ITEMS >= RUN_ITEMS);
      wait_idle(DRAIN_CYCLES);
      idle_on = !quiet && ($urandom_range(0, 2) != 0);

      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 3))
          0:       write_reg(REG_CONTACT_LIMIT, 20'd0);
          1:       write_reg(REG_CONTACT_LIMIT, 20'hFFFFF);
          2:       write_reg(REG_CONTACT_LIMIT, 20'($urandom_range(0, 8191)));
          default: write_reg(REG_CONTACT_LIMIT, 20'($urandom));
        endcase
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 9))
          0:       write_reg(REG_ATOM_COUNT, 20'd0);
          1:       write_reg(REG_ATOM_COUNT, 20'd127);
          2:       write_reg(REG_ATOM_COUNT, 20'd64);
          3:       write_reg(REG_ATOM_COUNT, 20'($urandom_range(9, 63)));
          default: write_reg(REG_ATOM_COUNT, 20'($urandom_range(1, 8)));
        endcase
      end
      // lattice vectors, often of zero length
      for (k = 0; k < 3; k++) begin
        if ($urandom_range(0, 1) == 0) begin
          vstart = IN_IDX_W'($urandom);
          write_reg(cfg_reg_e'(REG_VEC_A_START + 2 * k), 20'(vstart));
          write_reg(cfg_reg_e'(REG_VEC_A_STOP + 2 * k),
                    ($urandom_range(0, 1) == 0) ? 20'(vstart) : 20'($urandom_range(0, 63)));
        end
      end

      // long result-side hold-off while words keep coming
      if (round == 2) hold_req = 1'b1;

      n = $urandom_range(8, 16);
      for (int i = 0; i < n; i++) begin
        // sender pause until every result is in
        if (round == 4 && i == n / 2) wait_idle(0);
        case ($urandom_range(0, 9))
          0: send_word(FUNC_LOAD, IN_IDX_W'($urandom), rand_coord(), rand_coord(),
                       rand_coord(), 8'($urandom), 4'($urandom));
          1: send_word(FUNC_SCAN, IN_IDX_W'($urandom), 20'($urandom), 20'($urandom),
                       20'($urandom), 8'($urandom), CODE_W'($urandom_range(13, 15)));
          default: begin
            if (cur_count > 0 && $urandom_range(0, 3) != 0)
              row = IN_IDX_W'($urandom_range(0, cur_count - 1));
            else
              row = IN_IDX_W'($urandom);
            send_word(FUNC_SCAN, row, 20'($urandom), 20'($urandom), 20'($urandom),
                      8'($urandom), CODE_W'($urandom_range(0, NUM_CODES - 1)));
          end
        endcase
      end
      round++;
    end

    wait_idle(DRAIN_CYCLES);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== periodic_close_contact_check.f =====
design/pccc_pkg.sv
design/pccc_if.sv
design/pccc_cfg.sv
design/pccc_ctrl.sv
design/pccc_dp.sv
design/periodic_close_contact_check.sv
dv/pccc_contact_monitor.sv
dv/tb_periodic_close_contact_check.sv
